// ===== rtl/gdc_pkg.sv =====
`timescale 1ns / 1ps
// gdc_pkg: constants, codes and shared types of the gamepad deadzone conditioner
// used by every module under rtl; depends on nothing

package gdc_pkg;

  localparam int OUT_FRAC_BITS = 15;
  localparam int LIM_BITS      = (OUT_FRAC_BITS > 15) ? 15 : OUT_FRAC_BITS;
  localparam int SAT_SHIFT     = OUT_FRAC_BITS - LIM_BITS;

  localparam int AXIS_W    = 16;
  localparam int TRIG_W    = 8;
  localparam int BTN_W     = 16;
  localparam int DZ_W      = 15;
  localparam int DELAY_W   = 16;
  localparam int SHTRIG_W  = 15;
  localparam int NUMX_W    = AXIS_W + SAT_SHIFT;
  localparam int CNT_W     = $clog2(LIM_BITS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int S_TDATA_W = 96;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 112;
  localparam int M_TUSER_W = 2;

  localparam logic [DZ_W-1:0]     STICK_FULL  = 15'd32767;
  localparam logic [DZ_W-1:0]     TRIG_FULL   = 15'd255;
  localparam logic [BTN_W-1:0]    BUTTON_MASK = 16'hF3FF;
  localparam logic [LIM_BITS-1:0] LIM         = '1;

  localparam logic [DZ_W-1:0]    LDZ_RST   = 15'd7849;
  localparam logic [DZ_W-1:0]    RDZ_RST   = 15'd8689;
  localparam logic [TRIG_W-1:0]  TH_RST    = 8'd30;
  localparam logic [DELAY_W-1:0] DELAY_RST = 16'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_DZ  = 2'd0,
    CFG_RIGHT_DZ = 2'd1,
    CFG_TRIG_TH  = 2'd2,
    CFG_DELAY    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    JOB_LX = 3'd0,
    JOB_LY = 3'd1,
    JOB_RX = 3'd2,
    JOB_RY = 3'd3,
    JOB_LT = 3'd4,
    JOB_RT = 3'd5
  } job_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_START,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic cap_in;
    logic skip_tick;
    logic drop_link;
    logic take_link;
    logic div_start;
    logic store_job;
    logic load_out;
    job_e job;
  } gdc_cmd_t;

  typedef struct packed {
    logic link_up;
    logic cool_nz;
    logic present;
    logic div_done;
  } gdc_stat_t;

  typedef struct packed {
    logic                connected;
    logic                polled;
    logic [BTN_W-1:0]    buttons;
    logic                lt_pressed;
    logic                rt_pressed;
    logic [AXIS_W-1:0]   left_x;
    logic [AXIS_W-1:0]   left_y;
    logic [AXIS_W-1:0]   right_x;
    logic [AXIS_W-1:0]   right_y;
    logic [SHTRIG_W-1:0] left_trigger;
    logic [SHTRIG_W-1:0] right_trigger;
  } gdc_res_t;

endpackage

// ===== rtl/gdc_div.sv =====
`timescale 1ns / 1ps
// gdc_div: shared restoring divider, one quotient bit per cycle
// depends on gdc_pkg

module gdc_div
  import gdc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [AXIS_W-1:0]   num_i,
  input  logic [DZ_W-1:0]     den_i,
  output logic                done_o,
  output logic [LIM_BITS-1:0] quot_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DZ_W-1:0]     rem_q, rem_d;
  logic [DZ_W-1:0]     den_q, den_d;
  logic [LIM_BITS-1:0] quot_q, quot_d;
  logic [NUMX_W-1:0]   numx;
  logic [DZ_W:0]       shifted;
  logic [DZ_W:0]       trial;
  logic                ge;

  assign numx    = NUMX_W'(num_i) << SAT_SHIFT;
  assign shifted = {rem_q, 1'b0};
  assign ge      = shifted >= {1'b0, den_q};
  assign trial   = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(LIM_BITS);
      rem_d  = numx[DZ_W-1:0];
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? trial[DZ_W-1:0] : shifted[DZ_W-1:0];
      quot_d = LIM_BITS'({quot_q, ge});
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/gdc_dp.sv =====
`timescale 1ns / 1ps
// gdc_dp: datapath with config registers, link state, operand select and result registers
// depends on gdc_pkg and gdc_div

module gdc_dp
  import gdc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [S_TDATA_W-1:0]  in_data_i,
  input  logic                  in_present_i,
  input  gdc_cmd_t              cmd_i,
  output gdc_stat_t             stat_o,
  output gdc_res_t              out_o
);

  logic [DZ_W-1:0]    ldz_q, rdz_q;
  logic [TRIG_W-1:0]  th_q;
  logic [DELAY_W-1:0] delay_q;
  logic               link_q, link_d;
  logic [DELAY_W-1:0] cool_q, cool_d;

  logic [S_TDATA_W-1:0] data_q;
  logic                 present_q;
  gdc_res_t             res_q, res_d;
  gdc_res_t             out_q;

  logic [BTN_W-1:0]  raw_btn;
  logic [TRIG_W-1:0] raw_lt, raw_rt;
  logic [AXIS_W-1:0] raw_lx, raw_ly, raw_rx, raw_ry;

  logic [AXIS_W-1:0]   sel_raw;
  logic                sel_stick;
  logic [DZ_W-1:0]     sel_dz;
  logic                neg;
  logic [AXIS_W-1:0]   mag;
  logic [AXIS_W-1:0]   n;
  logic [DZ_W-1:0]     den;
  logic                zero;
  logic                sat;
  logic [NUMX_W-1:0]   numx;
  logic [LIM_BITS-1:0] quot;
  logic [LIM_BITS-1:0] val;
  logic [AXIS_W-1:0]   val16;
  logic [AXIS_W-1:0]   sval;

  assign raw_btn = data_q[15:0];
  assign raw_lt  = data_q[23:16];
  assign raw_rt  = data_q[31:24];
  assign raw_lx  = data_q[47:32];
  assign raw_ly  = data_q[63:48];
  assign raw_rx  = data_q[79:64];
  assign raw_ry  = data_q[95:80];

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ldz_q   <= LDZ_RST;
      rdz_q   <= RDZ_RST;
      th_q    <= TH_RST;
      delay_q <= DELAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LEFT_DZ:  ldz_q   <= cfg_wdata_i[DZ_W-1:0];
        CFG_RIGHT_DZ: rdz_q   <= cfg_wdata_i[DZ_W-1:0];
        CFG_TRIG_TH:  th_q    <= cfg_wdata_i[TRIG_W-1:0];
        CFG_DELAY:    delay_q <= cfg_wdata_i[DELAY_W-1:0];
        default:      ;
      endcase
    end
  end

  // operand select
  always_comb begin
    case (cmd_i.job)
      JOB_LX:  begin sel_raw = raw_lx; sel_stick = 1'b1; sel_dz = ldz_q; end
      JOB_LY:  begin sel_raw = raw_ly; sel_stick = 1'b1; sel_dz = ldz_q; end
      JOB_RX:  begin sel_raw = raw_rx; sel_stick = 1'b1; sel_dz = rdz_q; end
      JOB_RY:  begin sel_raw = raw_ry; sel_stick = 1'b1; sel_dz = rdz_q; end
      JOB_LT:  begin
        sel_raw = AXIS_W'(raw_lt); sel_stick = 1'b0; sel_dz = DZ_W'(th_q);
      end
      JOB_RT:  begin
        sel_raw = AXIS_W'(raw_rt); sel_stick = 1'b0; sel_dz = DZ_W'(th_q);
      end
      default: begin sel_raw = '0; sel_stick = 1'b0; sel_dz = '0; end
    endcase
  end

  assign neg  = sel_stick & sel_raw[AXIS_W-1];
  assign mag  = neg ? (~sel_raw + AXIS_W'(1)) : sel_raw;
  assign zero = mag <= AXIS_W'(sel_dz);
  assign n    = mag - AXIS_W'(sel_dz);
  assign den  = (sel_stick ? STICK_FULL : TRIG_FULL) - sel_dz;
  assign numx = NUMX_W'(n) << SAT_SHIFT;
  assign sat  = numx >= NUMX_W'(den);

  gdc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (n),
    .den_i  (den),
    .done_o (stat_o.div_done),
    .quot_o (quot)
  );

  assign val   = zero ? '0 : (sat ? LIM : quot);
  assign val16 = AXIS_W'(val);
  assign sval  = neg ? (~val16 + AXIS_W'(1)) : val16;

  // link state and result register
  always_comb begin
    link_d = link_q;
    cool_d = cool_q;
    res_d  = res_q;
    if (cmd_i.skip_tick) begin
      cool_d = cool_q - DELAY_W'(1);
      res_d  = '0;
    end
    if (cmd_i.drop_link) begin
      link_d       = 1'b0;
      cool_d       = delay_q;
      res_d        = '0;
      res_d.polled = 1'b1;
    end
    if (cmd_i.take_link) begin
      link_d           = 1'b1;
      res_d            = '0;
      res_d.connected  = 1'b1;
      res_d.polled     = 1'b1;
      res_d.buttons    = raw_btn & BUTTON_MASK;
      res_d.lt_pressed = raw_lt > th_q;
      res_d.rt_pressed = raw_rt > th_q;
    end
    if (cmd_i.store_job) begin
      case (cmd_i.job)
        JOB_LX:  res_d.left_x        = sval;
        JOB_LY:  res_d.left_y        = sval;
        JOB_RX:  res_d.right_x       = sval;
        JOB_RY:  res_d.right_y       = sval;
        JOB_LT:  res_d.left_trigger  = SHTRIG_W'(val);
        JOB_RT:  res_d.right_trigger = SHTRIG_W'(val);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= 1'b0;
      cool_q <= '0;
    end else begin
      link_q <= link_d;
      cool_q <= cool_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.cap_in) begin
      data_q    <= in_data_i;
      present_q <= in_present_i;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign stat_o.link_up = link_q;
  assign stat_o.cool_nz = cool_q != '0;
  assign stat_o.present = present_q;
  assign out_o          = out_q;

endmodule

// ===== rtl/gdc_ctrl.sv =====
`timescale 1ns / 1ps
// gdc_ctrl: controller state machine, sequences one report through the datapath
// depends on gdc_pkg

module gdc_ctrl
  import gdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  gdc_stat_t stat_i,
  output gdc_cmd_t  cmd_o
);

  state_e state_q, state_d;
  job_e   job_q, job_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.job   = job_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!stat_i.link_up && stat_i.cool_nz) begin
          cmd_o.skip_tick = 1'b1;
          state_d         = ST_DONE;
        end else if (!stat_i.present) begin
          cmd_o.drop_link = 1'b1;
          state_d         = ST_DONE;
        end else begin
          cmd_o.take_link = 1'b1;
          job_d           = JOB_LX;
          state_d         = ST_START;
        end
      end
      ST_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.store_job = 1'b1;
          if (job_q == JOB_RT) begin
            state_d = ST_DONE;
          end else begin
            job_d   = job_e'(job_q + 3'd1);
            state_d = ST_START;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JOB_LX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/gamepad_deadzone_conditioner.sv =====
`timescale 1ns / 1ps
// gamepad_deadzone_conditioner: top level, stream ports and field packing
// depends on gdc_pkg, gdc_ctrl and gdc_dp (which holds gdc_div)
// a skipped or absent-controller report goes from ST_DECIDE through ST_DONE into the output register;
// a present one first runs the six axis and trigger jobs one after another through the divider
// a new report is taken only after the last one is loaded out, as the single divider is shared
// reset clears link state, cooldown and handshakes and loads the config reset values

module gamepad_deadzone_conditioner
  import gdc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // raw_buttons, raw_left_trigger, raw_right_trigger, raw_left_x, raw_left_y,
  // raw_right_x, raw_right_y
  input  logic [S_TDATA_W-1:0]  s_axis_tdata_i,
  // device_present
  input  logic [S_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // buttons, left_trigger_pressed, right_trigger_pressed, left_x, left_y,
  // right_x, right_y, left_trigger, right_trigger
  output logic [M_TDATA_W-1:0]  m_axis_tdata_o,
  // connected, polled
  output logic [M_TUSER_W-1:0]  m_axis_tuser_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  gdc_cmd_t  cmd;
  gdc_stat_t stat;
  gdc_res_t  res;

  gdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gdc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .in_present_i(s_axis_tuser_i[0]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_o       (res)
  );

  assign m_axis_tdata_o = {res.right_trigger, res.left_trigger,
                           res.right_y, res.right_x, res.left_y, res.left_x,
                           res.rt_pressed, res.lt_pressed, res.buttons};
  assign m_axis_tuser_o = {res.polled, res.connected};

endmodule

// ===== tb/gamepad_deadzone_conditioner_tb.sv =====
`timescale 1ns / 1ps
// gamepad_deadzone_conditioner_tb: self-checking bench for the deadzone conditioner,
// a directed table at reset settings, then random reports under several settings
// depends on gdc_pkg and gamepad_deadzone_conditioner

module gamepad_deadzone_conditioner_tb;
  import gdc_pkg::*;

  localparam longint FULL_Q   = (longint'(1) << OUT_FRAC_BITS) - 1;
  localparam longint SAT_LIM  = (FULL_Q > 32767) ? 32767 : FULL_Q;
  localparam int     PHASES   = 8;
  localparam int     PER_PHASE = 130;
  localparam int     DRAIN    = 120;

  typedef struct packed {
    logic              present;
    logic [BTN_W-1:0]  buttons;
    logic [TRIG_W-1:0] lt;
    logic [TRIG_W-1:0] rt;
    logic [AXIS_W-1:0] lx;
    logic [AXIS_W-1:0] ly;
    logic [AXIS_W-1:0] rx;
    logic [AXIS_W-1:0] ry;
  } report_t;

  typedef enum {EXP_PRED, EXP_SKIP, EXP_POLLED, EXP_CONN, EXP_FULL} exp_kind_e;

  typedef struct {
    report_t   rpt;
    int        reps;
    exp_kind_e kind;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [S_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [S_TUSER_W-1:0]  s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;
  logic [M_TUSER_W-1:0]  m_axis_tuser_o;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i     = '0;

  gamepad_deadzone_conditioner dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // conditioner state and settings as the bench sees them
  logic               link_model;
  logic [DELAY_W-1:0] cooldown_model;
  logic [DZ_W-1:0]    left_dz_cfg;
  logic [DZ_W-1:0]    right_dz_cfg;
  logic [TRIG_W-1:0]  thresh_cfg;
  logic [DELAY_W-1:0] delay_cfg;

  gdc_res_t  pending_reports[$];
  stim_row_t stim_rows[$];
  int        mismatch_cnt = 0;
  int        result_no    = 0;
  int        tx_burst     = 0;
  int        rx_burst     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [AXIS_W-1:0] shape_axis(logic [AXIS_W-1:0] v, logic [DZ_W-1:0] dz);
    longint mag;
    longint den;
    longint q;
    mag = v[AXIS_W-1] ? 65536 - longint'(v) : longint'(v);
    if (mag <= longint'(dz)) return '0;
    den = 32767 - longint'(dz);
    q = (den == 0) ? SAT_LIM : ((mag - longint'(dz)) << OUT_FRAC_BITS) / den;
    if (q > SAT_LIM) q = SAT_LIM;
    return v[AXIS_W-1] ? AXIS_W'(65536 - q) : AXIS_W'(q);
  endfunction

  function automatic logic [SHTRIG_W-1:0] shape_trig(logic [TRIG_W-1:0] t, logic [TRIG_W-1:0] th);
    longint q;
    if (t <= th) return '0;
    q = ((longint'(t) - longint'(th)) << OUT_FRAC_BITS) / (255 - longint'(th));
    if (q > SAT_LIM) q = SAT_LIM;
    return SHTRIG_W'(q);
  endfunction

  function automatic gdc_res_t condition_report(report_t r);
    gdc_res_t res;
    res = '0;
    if (!link_model && cooldown_model != 0) begin
      cooldown_model = cooldown_model - 1'b1;
      return res;
    end
    res.polled = 1'b1;
    if (!r.present) begin
      link_model     = 1'b0;
      cooldown_model = delay_cfg;
      return res;
    end
    link_model        = 1'b1;
    res.connected     = 1'b1;
    res.buttons       = r.buttons & BUTTON_MASK;
    res.lt_pressed    = r.lt > thresh_cfg;
    res.rt_pressed    = r.rt > thresh_cfg;
    res.left_x        = shape_axis(r.lx, left_dz_cfg);
    res.left_y        = shape_axis(r.ly, left_dz_cfg);
    res.right_x       = shape_axis(r.rx, right_dz_cfg);
    res.right_y       = shape_axis(r.ry, right_dz_cfg);
    res.left_trigger  = shape_trig(r.lt, thresh_cfg);
    res.right_trigger = shape_trig(r.rt, thresh_cfg);
    return res;
  endfunction

  function automatic gdc_res_t typed_result(exp_kind_e k);
    gdc_res_t r;
    r = '0;
    r.polled    = (k != EXP_SKIP);
    r.connected = (k == EXP_CONN || k == EXP_FULL);
    if (k == EXP_FULL) begin
      r.buttons       = BUTTON_MASK;
      r.lt_pressed    = 1'b1;
      r.rt_pressed    = 1'b1;
      r.left_x        = 16'h8001;
      r.left_y        = 16'h7fff;
      r.right_x       = 16'h8001;
      r.right_y       = 16'h7fff;
      r.left_trigger  = '1;
      r.right_trigger = '1;
    end
    return r;
  endfunction

  function automatic void add_row(logic p, logic [BTN_W-1:0] b, logic [TRIG_W-1:0] l,
                                  logic [TRIG_W-1:0] r, logic [AXIS_W-1:0] lx,
                                  logic [AXIS_W-1:0] ly, logic [AXIS_W-1:0] rx,
                                  logic [AXIS_W-1:0] ry, int reps, exp_kind_e k);
    stim_row_t row;
    row.rpt  = '{present: p, buttons: b, lt: l, rt: r, lx: lx, ly: ly, rx: rx, ry: ry};
    row.reps = reps;
    row.kind = k;
    stim_rows.push_back(row);
  endfunction

  // zero gaps come in bursts so that stretches of back-to-back transfers occur
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [AXIS_W-1:0] pick_axis(logic [DZ_W-1:0] dz);
    logic [AXIS_W:0] above;
    above = {2'b00, dz} + 1'b1;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h8001;
      3: return AXIS_W'(dz);
      4: return AXIS_W'(-longint'(dz));
      5: return above[AXIS_W-1:0];
      6: return AXIS_W'(-longint'(above));
      7: return '0;
      default: return AXIS_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [TRIG_W-1:0] pick_trig();
    case ($urandom_range(0, 5))
      0: return thresh_cfg;
      1: return thresh_cfg + 1'b1;
      2: return '0;
      3: return '1;
      default: return TRIG_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic report_t random_report();
    report_t r;
    r.present = ($urandom_range(0, 9) != 0);
    r.buttons = BTN_W'($urandom_range(0, 65535));
    r.lt      = pick_trig();
    r.rt      = pick_trig();
    r.lx      = pick_axis(left_dz_cfg);
    r.ly      = pick_axis(left_dz_cfg);
    r.rx      = pick_axis(right_dz_cfg);
    r.ry      = pick_axis(right_dz_cfg);
    return r;
  endfunction

  task automatic send_report(input report_t r, input exp_kind_e kind, output logic polled);
    int       gap;
    gdc_res_t res;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {r.ry, r.rx, r.ly, r.lx, r.rt, r.lt, r.buttons};
    s_axis_tuser_i  <= r.present;
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = condition_report(r);
    if (kind != EXP_PRED) res = typed_result(kind);
    polled = res.polled;
    pending_reports.push_back(res);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_LEFT_DZ:  left_dz_cfg  = val[DZ_W-1:0];
      CFG_RIGHT_DZ: right_dz_cfg = val[DZ_W-1:0];
      CFG_TRIG_TH:  thresh_cfg   = val[TRIG_W-1:0];
      CFG_DELAY:    delay_cfg    = val[DELAY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_cnt++;
  endtask

  task automatic compare_field(input string name, input longint unsigned got,
                               input longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", result_no, name, got, want));
  endtask

  // result side
  initial begin
    int       gap;
    gdc_res_t got;
    gdc_res_t want;
    forever begin
      gap = draw_gap(rx_burst);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got.connected     = m_axis_tuser_o[0];
      got.polled        = m_axis_tuser_o[1];
      got.buttons       = m_axis_tdata_o[15:0];
      got.lt_pressed    = m_axis_tdata_o[16];
      got.rt_pressed    = m_axis_tdata_o[17];
      got.left_x        = m_axis_tdata_o[33:18];
      got.left_y        = m_axis_tdata_o[49:34];
      got.right_x       = m_axis_tdata_o[65:50];
      got.right_y       = m_axis_tdata_o[81:66];
      got.left_trigger  = m_axis_tdata_o[96:82];
      got.right_trigger = m_axis_tdata_o[111:97];
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", result_no));
      end else begin
        want = pending_reports.pop_front();
        compare_field("connected", got.connected, want.connected);
        compare_field("polled", got.polled, want.polled);
        compare_field("buttons", got.buttons, want.buttons);
        compare_field("left_trigger_pressed", got.lt_pressed, want.lt_pressed);
        compare_field("right_trigger_pressed", got.rt_pressed, want.rt_pressed);
        compare_field("left_x", got.left_x, want.left_x);
        compare_field("left_y", got.left_y, want.left_y);
        compare_field("right_x", got.right_x, want.right_x);
        compare_field("right_y", got.right_y, want.right_y);
        compare_field("left_trigger", got.left_trigger, want.left_trigger);
        compare_field("right_trigger", got.right_trigger, want.right_trigger);
      end
      result_no++;
    end
  end

  // report side
  initial begin
    logic    polled;
    int      polled_cnt;
    report_t r;

    link_model     = 1'b0;
    cooldown_model = '0;
    left_dz_cfg    = LDZ_RST;
    right_dz_cfg   = RDZ_RST;
    thresh_cfg     = TH_RST;
    delay_cfg      = DELAY_RST;

    // reset settings: deadzones 7849 / 8689, threshold 30, reconnect delay 120
    add_row(1, 16'h0000, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, EXP_CONN);
    add_row(1, 16'hffff, 8'd255, 8'd255, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1, EXP_FULL);
    add_row(1, 16'h0c00, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, EXP_CONN);
    add_row(1, 16'h1234, 8'd30, 8'd31, 16'(7849), 16'(-7849), 16'(8689), 16'(-8689), 1,
            EXP_PRED);
    add_row(1, 16'h5555, 8'd0, 8'd254, 16'(7850), 16'(-7850), 16'(8690), 16'(-8690), 1,
            EXP_PRED);
    add_row(1, 16'haaaa, 8'd128, 8'd31, 16'h8001, 16'h0001, 16'h7ffe, 16'hffff, 1, EXP_PRED);
    add_row(1, 16'h8421, 8'd200, 8'd77, 16'h4000, 16'hc000, 16'h2345, 16'hdcba, 1, EXP_PRED);
    // absent controller, then the whole cooldown is skipped whatever comes in
    add_row(0, 16'hffff, 8'd255, 8'd255, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1,
            EXP_POLLED);
    add_row(1, 16'hffff, 8'd255, 8'd255, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 120,
            EXP_SKIP);
    add_row(1, 16'h0000, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, EXP_CONN);
    add_row(0, 16'h0000, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, EXP_POLLED);
    add_row(0, 16'h0000, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 120, EXP_SKIP);
    add_row(0, 16'h0000, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, EXP_POLLED);
    add_row(1, 16'h0000, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 120, EXP_SKIP);
    add_row(1, 16'hffff, 8'd255, 8'd255, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1, EXP_FULL);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i])
      repeat (stim_rows[i].reps) send_report(stim_rows[i].rpt, stim_rows[i].kind, polled);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_cfg(CFG_LEFT_DZ, 16'd0);
          write_cfg(CFG_RIGHT_DZ, 16'd0);
          write_cfg(CFG_TRIG_TH, 16'd0);
          write_cfg(CFG_DELAY, 16'd0);
        end
        1: begin
          write_cfg(CFG_LEFT_DZ, 16'd32766);
          write_cfg(CFG_RIGHT_DZ, 16'd32767);
          write_cfg(CFG_TRIG_TH, 16'd254);
          write_cfg(CFG_DELAY, 16'd1);
        end
        2: begin
          write_cfg(CFG_LEFT_DZ, 16'd32767);
          write_cfg(CFG_RIGHT_DZ, 16'd32766);
          write_cfg(CFG_TRIG_TH, 16'd255);
          write_cfg(CFG_DELAY, 16'd0);
        end
        default: begin
          write_cfg(CFG_LEFT_DZ, CFG_DATA_W'($urandom_range(0, 32767)));
          write_cfg(CFG_RIGHT_DZ, CFG_DATA_W'($urandom_range(0, 32767)));
          write_cfg(CFG_TRIG_TH, CFG_DATA_W'($urandom_range(0, 255)));
          write_cfg(CFG_DELAY, CFG_DATA_W'($urandom_range(0, 6)));
        end
      endcase
      polled_cnt = 0;
      while (polled_cnt < PER_PHASE) begin
        send_report(random_report(), EXP_PRED, polled);
        if (polled) polled_cnt++;
      end
    end

    // longest reconnect delay: load it, then run a few skipped ticks
    wait_idle();
    write_cfg(CFG_DELAY, 16'hffff);
    r = random_report();
    r.present = 1'b1;
    send_report(r, EXP_PRED, polled);
    r = random_report();
    r.present = 1'b0;
    send_report(r, EXP_PRED, polled);
    repeat (4) send_report(random_report(), EXP_PRED, polled);

    wait_idle();
    repeat (DRAIN) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
